// File: rtl/totp_pkg.sv
package totp_pkg;

    typedef struct packed {
        logic [63:0] unix_time;
        logic [19:0] given_code;
    } t_in_word;

    typedef struct packed {
        logic        code_valid;
        logic [19:0] computed_code;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_TRUNC,
        S_MOD,
        S_DONE
    } t_state;

    // block order: inner key pad, inner counter, outer key pad, outer digest
    typedef enum logic [1:0] {
        BLK_IKEY,
        BLK_ICTR,
        BLK_OKEY,
        BLK_ODIG
    } t_blk;

    typedef struct packed {
        logic       capture;
        logic       div_step;
        logic       blk_load;
        t_blk       blk;
        logic       round;
        logic [6:0] rnd;
        logic       h_add;
        logic       trunc;
        logic       mod_step;
        logic       done;
    } t_cmd;

    // config register indexes
    localparam logic        REG_KEY_HIGH = 1'b0;
    localparam logic        REG_KEY_LOW  = 1'b1;

    localparam logic [5:0]  TIME_STEP  = 6'd30;
    localparam logic [20:0] CODE_MOD   = 21'd1000000;
    localparam logic [31:0] IPAD       = 32'h36363636;
    localparam logic [31:0] OPAD       = 32'h5c5c5c5c;
    localparam logic [31:0] PAD_ONE    = 32'h80000000;
    localparam logic [31:0] ILEN_BITS  = 32'd576;
    localparam logic [31:0] OLEN_BITS  = 32'd672;
    localparam logic [6:0]  DIV_LAST   = 7'd3;
    localparam logic [6:0]  ROUND_LAST = 7'd79;
    localparam logic [6:0]  MOD_LAST   = 7'd1;

    // ceil(2^26 / 30): exact quotient for dividends below 30 * 2^16
    localparam logic [21:0] DIV_RECIP  = 22'd2236963;
    // ceil(2^51 / 10^6): exact quotient for 31-bit dividends
    localparam logic [31:0] MOD_RECIP  = 32'd2251799814;

    localparam logic [31:0] H0_0 = 32'h67452301;
    localparam logic [31:0] H0_1 = 32'hEFCDAB89;
    localparam logic [31:0] H0_2 = 32'h98BADCFE;
    localparam logic [31:0] H0_3 = 32'h10325476;
    localparam logic [31:0] H0_4 = 32'hC3D2E1F0;

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

endpackage

// File: rtl/totp_ctrl.sv
module totp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output totp_pkg::t_cmd   o_cmd
);

    totp_pkg::t_state r_state, n_state;
    logic [6:0]       r_cnt, n_cnt;
    totp_pkg::t_blk   r_blk, n_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= totp_pkg::S_IDLE;
            r_cnt   <= '0;
            r_blk   <= totp_pkg::BLK_IKEY;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_blk   <= n_blk;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_blk   = r_blk;
        o_cmd   = '0;
        o_cmd.blk = r_blk;
        o_cmd.rnd = r_cnt;
        o_busy  = (r_state != totp_pkg::S_IDLE);
        case (r_state)
            totp_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_cnt   = '0;
                    n_state = totp_pkg::S_DIV;
                end
            end
            totp_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == totp_pkg::DIV_LAST) begin
                    n_blk   = totp_pkg::BLK_IKEY;
                    n_state = totp_pkg::S_LOAD;
                end
            end
            totp_pkg::S_LOAD: begin
                o_cmd.blk_load = 1'b1;
                n_cnt   = '0;
                n_state = totp_pkg::S_ROUND;
            end
            totp_pkg::S_ROUND: begin
                o_cmd.round = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == totp_pkg::ROUND_LAST) begin
                    n_state = totp_pkg::S_ADD;
                end
            end
            totp_pkg::S_ADD: begin
                o_cmd.h_add = 1'b1;
                if (r_blk == totp_pkg::BLK_ODIG) begin
                    n_state = totp_pkg::S_TRUNC;
                end else begin
                    n_blk   = totp_pkg::t_blk'(r_blk + 2'd1);
                    n_state = totp_pkg::S_LOAD;
                end
            end
            totp_pkg::S_TRUNC: begin
                o_cmd.trunc = 1'b1;
                n_cnt   = '0;
                n_state = totp_pkg::S_MOD;
            end
            totp_pkg::S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == totp_pkg::MOD_LAST) begin
                    n_state = totp_pkg::S_DONE;
                end
            end
            totp_pkg::S_DONE: begin
                o_cmd.done = 1'b1;
                n_state = totp_pkg::S_IDLE;
            end
            default: begin
                n_state = totp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/totp_dp.sv
module totp_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  totp_pkg::t_cmd       i_cmd,
    input  totp_pkg::t_in_word   i_in,
    input  logic [79:0]          i_key,
    output logic                 o_res_valid,
    output totp_pkg::t_out_word  o_res
);

    // time / 30, 16 quotient bits per cycle by reciprocal multiply
    logic [63:0] r_dq;
    logic [4:0]  r_drem;
    logic [19:0] r_given;
    logic [20:0] div_v;
    logic [41:0] div_prod;
    logic [15:0] div_q;
    logic [20:0] div_qx;

    // SHA-1 state
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_h [5];
    logic [31:0] r_ih [5];
    logic [31:0] r_win [16];
    logic [31:0] blk_w [16];
    logic [31:0] f, k, wt, w_new, tmp;

    // truncation and mod 10^6: quotient cycle, then remainder cycle
    logic [30:0]  r_mw;
    logic [11:0]  r_mq;
    logic [19:0]  r_mrem;
    logic [62:0]  mod_prod;
    logic [30:0]  mod_qx;
    logic [159:0] digest, dig_sh;

    logic         r_out_vld;
    totp_pkg::t_out_word r_out;

    assign div_v    = {r_drem, r_dq[63:48]};
    assign div_prod = 42'(div_v) * 42'(totp_pkg::DIV_RECIP);
    assign div_q    = div_prod[41:26];
    assign div_qx   = 21'(div_q) * 21'(totp_pkg::TIME_STEP);

    assign mod_prod = 63'(r_mw) * 63'(totp_pkg::MOD_RECIP);
    assign mod_qx   = 31'(r_mq) * 31'(totp_pkg::CODE_MOD);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            blk_w[i] = 32'h0;
        end
        case (i_cmd.blk)
            totp_pkg::BLK_IKEY, totp_pkg::BLK_OKEY: begin
                blk_w[0] = i_key[79:48];
                blk_w[1] = i_key[47:16];
                blk_w[2] = {i_key[15:0], 16'h0};
                for (int i = 0; i < 16; i++) begin
                    blk_w[i] = blk_w[i] ^ ((i_cmd.blk == totp_pkg::BLK_IKEY) ?
                                           totp_pkg::IPAD : totp_pkg::OPAD);
                end
            end
            totp_pkg::BLK_ICTR: begin
                blk_w[0]  = r_dq[63:32];
                blk_w[1]  = r_dq[31:0];
                blk_w[2]  = totp_pkg::PAD_ONE;
                blk_w[15] = totp_pkg::ILEN_BITS;
            end
            default: begin
                // r_h holds the outer chain by now; inner digest is the saved copy
                for (int i = 0; i < 5; i++) begin
                    blk_w[i] = r_ih[i];
                end
                blk_w[5]  = totp_pkg::PAD_ONE;
                blk_w[15] = totp_pkg::OLEN_BITS;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = totp_pkg::K_0;
        end else if (i_cmd.rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = totp_pkg::K_1;
        end else if (i_cmd.rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = totp_pkg::K_2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = totp_pkg::K_3;
        end
        w_new = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        wt    = (i_cmd.rnd < 7'd16) ? r_win[0] : {w_new[30:0], w_new[31]};
        tmp   = {r_a[26:0], r_a[31:27]} + f + r_e + k + wt;
    end

    assign digest = {r_h[0], r_h[1], r_h[2], r_h[3], r_h[4]};
    assign dig_sh = digest << {r_h[4][3:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dq    <= i_in.unix_time;
            r_drem  <= '0;
            r_given <= i_in.given_code;
        end
        if (i_cmd.div_step) begin
            r_drem <= 5'(div_v - div_qx);
            r_dq   <= {r_dq[47:0], div_q};
        end
        if (i_cmd.blk_load) begin
            for (int i = 0; i < 16; i++) begin
                r_win[i] <= blk_w[i];
            end
            if (i_cmd.blk == totp_pkg::BLK_IKEY || i_cmd.blk == totp_pkg::BLK_OKEY) begin
                r_h[0] <= totp_pkg::H0_0;
                r_h[1] <= totp_pkg::H0_1;
                r_h[2] <= totp_pkg::H0_2;
                r_h[3] <= totp_pkg::H0_3;
                r_h[4] <= totp_pkg::H0_4;
                r_a <= totp_pkg::H0_0;
                r_b <= totp_pkg::H0_1;
                r_c <= totp_pkg::H0_2;
                r_d <= totp_pkg::H0_3;
                r_e <= totp_pkg::H0_4;
            end else begin
                r_a <= r_h[0];
                r_b <= r_h[1];
                r_c <= r_h[2];
                r_d <= r_h[3];
                r_e <= r_h[4];
            end
            if (i_cmd.blk == totp_pkg::BLK_OKEY) begin
                for (int i = 0; i < 5; i++) begin
                    r_ih[i] <= r_h[i];
                end
            end
        end
        if (i_cmd.round) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tmp;
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[15] <= wt;
        end
        if (i_cmd.h_add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
        if (i_cmd.trunc) begin
            r_mw <= dig_sh[158:128];
        end
        if (i_cmd.mod_step) begin
            if (i_cmd.rnd == 7'd0) begin
                r_mq <= mod_prod[62:51];
            end else begin
                r_mrem <= 20'(r_mw - mod_qx);
            end
        end
        if (i_cmd.done) begin
            r_out.computed_code <= r_mrem;
            r_out.code_valid    <= (r_given == r_mrem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.done;
        end
    end

    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

// File: rtl/totp_code_checker.sv
// TOTP code checker: HMAC-SHA1 over floor(time/30), dynamic truncation,
// reduced modulo 10^6, compared against a claimed code.
//
// Input: raise i_start with i_in (unix_time, given_code); the word is taken
// on an edge where i_start is high and o_busy is low. o_busy drops in the
// cycle the result is shown, so the next word can be taken at that edge.
// Output: o_res_valid pulses for one cycle with o_res (code_valid,
// computed_code). The receiver cannot stall; the result must be taken then.
// Sequence: division by 30 (16 quotient bits per cycle by reciprocal
// multiply), four SHA-1 blocks (each a load, 80 rounds on a single round
// unit, and a digest add), a truncation step, mod 10^6 (reciprocal
// quotient, then remainder), a done step, then the output register.
// Only one word is in flight; the next is taken once o_busy drops.
// Config: i_cfg_we writes i_cfg_data into key_high (index 0, low 16 bits)
// or key_low (index 1). Write only while o_busy is low.
// Reset: synchronous active-low i_rst_n clears the key, control and strobe.
module totp_code_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  totp_pkg::t_in_word   i_in,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    output logic                 o_res_valid,
    output totp_pkg::t_out_word  o_res
);

    logic [15:0]    r_key_high;
    logic [63:0]    r_key_low;
    totp_pkg::t_cmd cmd;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == totp_pkg::REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data[15:0];
            end else begin
                r_key_low <= i_cfg_data;
            end
        end
    end

    totp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (cmd)
    );

    totp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_key       ({r_key_high, r_key_low}),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule
